/* design/tsp_pkg.sv */
// shared types and constants of the timed slot pool
package tsp_pkg;

   localparam int CMD_W    = 3;
   localparam int STAMP_W  = 32;
   localparam int DELTA_W  = 16;
   localparam int TIME_W   = 32;
   localparam int CFG_W    = 31;
   localparam int CSR_IDX_W = 2;
   localparam int REPORT_MAX = 8;

   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;

   localparam logic [1:0] MODE_FREE     = 2'd0;
   localparam logic [1:0] MODE_RUNNING  = 2'd1;
   localparam logic [1:0] MODE_DRAINING = 2'd2;
   localparam logic [1:0] MODE_PAUSED   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_RUN_DURATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DRAIN_LINGER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_DELAY  = 2'd2;

   localparam logic [TIME_W-1:0] TIME_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]              mode;
      logic                    inhibit;
      logic [TIME_W-1:0]       tval;
      logic [STAMP_W-1:0]      stamp;
      logic [TIME_W-1:0]       mark;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   typedef struct packed {
      logic load;
      logic rd_en;
      logic scan;
   } tsp_cmd_type;

   typedef struct packed {
      logic              valid;
      logic [2:0]        slot_index;
      logic [1:0]        slot_mode;
      logic [TIME_W-1:0] elapsed_time;
      logic              compute_now;
      logic              inhibited;
      logic              was_picked;
      logic              last_slot;
   } rsp_type;

endpackage

/* design/tsp_ram.sv */
// generic simple dual-port ram with registered read
module tsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tsp_ctrl.sv */
// sequencer of the slot pool: scan pass for start, then update pass
module tsp_ctrl import tsp_pkg::*; #(
   parameter int SLOTS = 8,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_command,
   output tsp_cmd_type      cmd,
   output logic [IDX_W-1:0] rd_addr,
   output logic             busy
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_PASS  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = (req_command == CMD_START) ? ST_SCAN : ST_PASS;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.scan  = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_PASS;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PASS: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_FLUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rd_addr = cnt_ff;
   assign busy    = (state_ff != ST_IDLE);

endmodule

/* design/tsp_datapath.sv */
// slot record store, per-slot update logic, eviction scan and result register
module tsp_datapath import tsp_pkg::*; #(
   parameter int SLOTS = 8,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsp_cmd_type          cmd,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [STAMP_W-1:0]   req_stamp_now,
   input  logic [DELTA_W-1:0]   req_delta_time,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output rsp_type              rsp
);

   localparam int REPORT = (SLOTS < REPORT_MAX) ? SLOTS : REPORT_MAX;

   logic [CFG_W-1:0]   run_dur_ff, linger_ff, delay_ff;
   logic [CMD_W-1:0]   command_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [DELTA_W-1:0] delta_ff;

   logic [SLOTS-1:0]   vld_ff;
   logic               rd_vld_ff, rd_scan_ff, entry_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;

   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff, min_idx_ff;
   logic [STAMP_W-1:0] min_stamp_ff;

   logic [REC_W-1:0]   ram_rdata;
   slot_rec_type       rec, nxt;
   logic               comp, picked, began, wr_en;
   logic [IDX_W-1:0]   pick_idx;

   logic [TIME_W:0]         adv_sum;
   logic                    adv_ovf;
   logic [TIME_W-1:0]       adv_time;
   logic                    hit_run, hit_linger;
   logic signed [TIME_W+1:0] linger_end;

   rsp_type rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_dur_ff <= '0;
         linger_ff  <= '0;
         delay_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_RUN_DURATION: run_dur_ff <= csr_wdata;
            REG_DRAIN_LINGER: linger_ff  <= csr_wdata;
            REG_START_DELAY:  delay_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         stamp_ff   <= req_stamp_now;
         delta_ff   <= req_delta_time;
      end
   end

   // read stage tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         vld_ff    <= '0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (wr_en) begin
            vld_ff[rd_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_scan_ff <= cmd.scan;
      rd_idx_ff  <= rd_addr;
      if (cmd.rd_en) begin
         entry_vld_ff <= vld_ff[rd_addr];
      end
   end

   tsp_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_idx_ff),
      .wr_data (nxt),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // never-written entries read as the reset record
   assign rec = entry_vld_ff ? slot_rec_type'(ram_rdata) : '0;

   // eviction scan: first free slot, else oldest start stamp
   always_ff @(posedge clock) begin
      if (rd_vld_ff && rd_scan_ff) begin
         if (rd_idx_ff == '0) begin
            free_found_ff <= (rec.mode == MODE_FREE);
            free_idx_ff   <= '0;
            min_idx_ff    <= '0;
            min_stamp_ff  <= rec.stamp;
         end else begin
            if (rec.stamp < min_stamp_ff) begin
               min_idx_ff   <= rd_idx_ff;
               min_stamp_ff <= rec.stamp;
            end
            if (!free_found_ff && rec.mode == MODE_FREE) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= rd_idx_ff;
            end
         end
      end
   end

   assign pick_idx = free_found_ff ? free_idx_ff : min_idx_ff;

   // tick arithmetic
   assign adv_sum    = {rec.tval[TIME_W-1], rec.tval} + {{(TIME_W+1-DELTA_W){1'b0}}, delta_ff};
   assign adv_ovf    = !adv_sum[TIME_W] && adv_sum[TIME_W-1];
   assign adv_time   = adv_ovf ? TIME_MAX : adv_sum[TIME_W-1:0];
   assign hit_run    = $signed({adv_time[TIME_W-1], adv_time}) >= $signed({2'b00, run_dur_ff});
   assign linger_end = $signed({{2{rec.mark[TIME_W-1]}}, rec.mark})
                     + $signed({3'b000, linger_ff});
   assign hit_linger = $signed({{2{adv_time[TIME_W-1]}}, adv_time}) >= linger_end;

   always_comb begin
      nxt    = rec;
      comp   = 1'b0;
      picked = 1'b0;
      began  = 1'b0;
      unique case (command_ff)
         CMD_TICK: begin
            if (rec.mode == MODE_RUNNING || rec.mode == MODE_DRAINING) begin
               nxt.tval = adv_time;
               comp     = !adv_time[TIME_W-1];
               began    = (rec.mode == MODE_RUNNING) && (run_dur_ff != '0) && hit_run;
               if (began) begin
                  nxt.mode    = MODE_DRAINING;
                  nxt.inhibit = 1'b1;
                  nxt.mark    = adv_time;
               end
               if ((rec.mode == MODE_DRAINING && hit_linger) ||
                   (began && linger_ff == '0)) begin
                  nxt.mode    = MODE_FREE;
                  nxt.inhibit = 1'b0;
                  nxt.tval    = '0;
                  nxt.mark    = '0;
               end
            end
         end
         CMD_START: begin
            if (rd_idx_ff == pick_idx) begin
               picked      = 1'b1;
               nxt.mode    = MODE_RUNNING;
               nxt.inhibit = 1'b0;
               nxt.stamp   = stamp_ff;
               nxt.tval    = '0 - {1'b0, delay_ff};
               nxt.mark    = '0;
            end
         end
         CMD_STOP: begin
            if (rec.mode == MODE_RUNNING || rec.mode == MODE_PAUSED) begin
               nxt.mode    = MODE_DRAINING;
               nxt.inhibit = 1'b1;
               nxt.mark    = rec.tval;
            end
         end
         CMD_PAUSE: begin
            if (rec.mode == MODE_RUNNING || rec.mode == MODE_DRAINING) begin
               nxt.mode = MODE_PAUSED;
            end
         end
         CMD_RESUME: begin
            if (rec.mode == MODE_PAUSED) begin
               nxt.mode = MODE_RUNNING;
            end
         end
         default: ;
      endcase
   end

   assign wr_en = rd_vld_ff && !rd_scan_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= wr_en && (int'(rd_idx_ff) < REPORT);
      end
      rsp_ff.slot_index   <= 3'(rd_idx_ff);
      rsp_ff.slot_mode    <= nxt.mode;
      rsp_ff.elapsed_time <= nxt.tval;
      rsp_ff.compute_now  <= comp;
      rsp_ff.inhibited    <= nxt.inhibit;
      rsp_ff.was_picked   <= picked;
      rsp_ff.last_slot    <= (int'(rd_idx_ff) == REPORT - 1);
   end

   assign rsp = rsp_ff;

endmodule

/* design/timed_slot_pool_oldest_eviction_top.sv */
// top level of the timed slot pool with oldest-slot eviction
//
// usage:
//   a command word (tick, start, stop, pause, resume) is taken on req_* when
//   start is high and busy is low. the block then walks every slot once
//   through a single-port-read record ram (a start walks them twice: a scan
//   pass, then the update pass), updates each slot and reports the first
//   eight slots in slot order on rsp_*, one word per cycle marked by
//   rsp_valid, with rsp_last_slot on the final one. each slot record is
//   read through the ram's registered read port and its result is held in
//   the result register; a start first scans all slots for a free or the
//   oldest one. the slot ram gives one record read per cycle, and a new
//   command word is taken only once busy is low again after the last slot.
//   csr_* writes the run duration, drain linger and start holdoff; write
//   only while busy is low and no result is pending.
//   reset clears the sequencer and marks every slot record unwritten, so
//   all slots read as free with zero time; no clearing pass is needed.
//   the receiver cannot stall: each result is shown for exactly one cycle.
module timed_slot_pool_oldest_eviction_top import tsp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [STAMP_W-1:0]   req_stamp_now,
   input  logic [DELTA_W-1:0]   req_delta_time,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_slot_index,
   output logic [1:0]           rsp_slot_mode,
   output logic signed [31:0]   rsp_elapsed_time,
   output logic                 rsp_compute_now,
   output logic                 rsp_inhibited,
   output logic                 rsp_was_picked,
   output logic                 rsp_last_slot
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   tsp_cmd_type      cmd;
   logic [IDX_W-1:0] rd_addr;
   rsp_type          rsp;

   tsp_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .busy        (busy)
   );

   tsp_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .req_command    (req_command),
      .req_stamp_now  (req_stamp_now),
      .req_delta_time (req_delta_time),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp            (rsp)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_slot_index   = rsp.slot_index;
   assign rsp_slot_mode    = rsp.slot_mode;
   assign rsp_elapsed_time = rsp.elapsed_time;
   assign rsp_compute_now  = rsp.compute_now;
   assign rsp_inhibited    = rsp.inhibited;
   assign rsp_was_picked   = rsp.was_picked;
   assign rsp_last_slot    = rsp.last_slot;

endmodule

/* design/tsp_checker.sv */
// port-level checks of the slot pool and their bind to the top level
module tsp_checker import tsp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_slot_mode,
   input logic signed [31:0] rsp_elapsed_time,
   input logic               rsp_compute_now,
   input logic               rsp_was_picked,
   input logic               rsp_last_slot
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_in_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word outside a job");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_slot) |=> !rsp_valid)
      else $error("result word right after the last slot");

   a_pick_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_picked) |-> (rsp_slot_mode == MODE_RUNNING))
      else $error("picked slot not running");

   a_compute_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compute_now) |-> !rsp_elapsed_time[31])
      else $error("compute flagged with negative time");

endmodule

bind timed_slot_pool_oldest_eviction_top tsp_checker u_checker (.*);
